### sv/atlb_pkg.sv
// Shared types and constants for the associative TLB.
// Used by atlb_cell and assoc_tlb_fifo_lru_top; depends on nothing.
`default_nettype none

package atlb_pkg;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 5;
    localparam int CAP_BITS      = 5;
    localparam int STAT_BITS     = 32;

    localparam logic                POLICY_FIFO  = 1'b0;
    localparam logic                POLICY_LRU   = 1'b1;
    localparam logic [CAP_BITS-1:0] CAPACITY_RST = 5'd16;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POLICY   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cell_cmd;

endpackage

`default_nettype wire

### sv/assoc_tlb_fifo_lru_top.sv
// Top level of the fully associative TLB with FIFO or LRU replacement.
// Depends on atlb_pkg and atlb_cell.
//
// Usage:
//   Request channel (i_valid / o_stall) carries one word per request: opcode
//   (lookup, insert, invalidate), vpn, frame and entry_valid. A word is taken
//   at a rising edge with i_valid high and o_stall low.
//   Result channel (o_valid / i_stall) returns one word per request: hit,
//   frame_out, occupancy and the saturating hit and miss totals. A word is
//   taken at a rising edge with o_valid high and i_stall low.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes policy
//   (index 0) and capacity (index 1); write only while no request is in flight.
// Timing:
//   One request per cycle while o_stall is low; the result appears in the cycle
//   after the request is taken. All entries sit in a chain of cells ordered by
//   age; each request is one parallel tag compare plus one shift of the chain.
// Reset:
//   Table empty, policy LRU, capacity 16, totals zero. No clearing pass.
// Stall:
//   While a result waits under i_stall, o_stall is raised and the result holds.
`default_nettype none

module assoc_tlb_fifo_lru_top #(
    parameter int ENTRIES    = 16,
    parameter int VPN_BITS   = 52,
    parameter int FRAME_BITS = 40
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [1:0]                          i_opcode,
    input  wire  [VPN_BITS-1:0]                 i_vpn,
    input  wire  [FRAME_BITS-1:0]               i_frame,
    input  wire                                 i_entry_valid,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_hit,
    output logic [FRAME_BITS-1:0]               o_frame_out,
    output logic [$clog2(ENTRIES+1)-1:0]        o_occupancy,
    output logic [atlb_pkg::STAT_BITS-1:0]      o_hit_total,
    output logic [atlb_pkg::STAT_BITS-1:0]      o_miss_total,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [atlb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire  [atlb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CMP_W = (CNT_W > atlb_pkg::CAP_BITS) ? CNT_W : atlb_pkg::CAP_BITS;

    logic                               r_policy;
    logic [atlb_pkg::CAP_BITS-1:0]      r_capacity;
    logic [CNT_W-1:0]                   r_count,   n_count;
    logic [atlb_pkg::STAT_BITS-1:0]     r_hit_cnt, n_hit_cnt;
    logic [atlb_pkg::STAT_BITS-1:0]     r_miss_cnt, n_miss_cnt;
    logic                               r_out_valid;
    logic                               r_hit,     n_hit;
    logic [FRAME_BITS-1:0]              r_frame_out, n_frame_out;

    logic [VPN_BITS-1:0]                w_tag   [ENTRIES];
    logic [FRAME_BITS-1:0]              w_frame [ENTRIES];
    logic [ENTRIES-1:0]                 w_valid;
    logic [ENTRIES-1:0]                 w_present;
    logic [ENTRIES-1:0]                 w_match;
    atlb_pkg::t_cell_cmd                w_cmd   [ENTRIES];

    logic                               w_accept;
    logic                               w_any;
    logic [IDX_W-1:0]                   w_sidx;
    logic [FRAME_BITS-1:0]              w_sel_frame;
    logic                               w_sel_valid;
    logic [CMP_W-1:0]                   w_eff_cap;
    logic                               w_full;
    logic [CNT_W-1:0]                   w_limit;
    logic                               w_promote;
    logic                               w_insert_new;
    logic                               w_drop;
    logic                               w_lookup;
    logic                               w_lookup_hit;
    logic [FRAME_BITS-1:0]              w_head_frame;
    logic                               w_head_valid;

    assign o_stall     = r_out_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= atlb_pkg::POLICY_LRU;
            r_capacity <= atlb_pkg::CAPACITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (atlb_pkg::t_cfg_reg'(i_cfg_index))
                atlb_pkg::CFG_POLICY:   r_policy   <= i_cfg_data[0];
                atlb_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[atlb_pkg::CAP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Chain of entries, newest at cell 0.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [VPN_BITS-1:0]   w_ltag,   w_rtag;
        logic [FRAME_BITS-1:0] w_lframe, w_rframe;
        logic                  w_lvalid, w_rvalid, w_lpres, w_rpres;

        if (g == 0) begin : g_first
            assign w_ltag   = '0;
            assign w_lframe = '0;
            assign w_lvalid = 1'b0;
            assign w_lpres  = 1'b0;
        end else begin : g_mid_l
            assign w_ltag   = w_tag[g-1];
            assign w_lframe = w_frame[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_lpres  = w_present[g-1];
        end

        if (g == ENTRIES - 1) begin : g_last
            assign w_rtag   = '0;
            assign w_rframe = '0;
            assign w_rvalid = 1'b0;
            assign w_rpres  = 1'b0;
        end else begin : g_mid_r
            assign w_rtag   = w_tag[g+1];
            assign w_rframe = w_frame[g+1];
            assign w_rvalid = w_valid[g+1];
            assign w_rpres  = w_present[g+1];
        end

        atlb_cell #(
            .VPN_BITS   (VPN_BITS),
            .FRAME_BITS (FRAME_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (w_cmd[g]),
            .i_key           (i_vpn),
            .i_left_tag      (w_ltag),
            .i_left_frame    (w_lframe),
            .i_left_valid    (w_lvalid),
            .i_left_present  (w_lpres),
            .i_right_tag     (w_rtag),
            .i_right_frame   (w_rframe),
            .i_right_valid   (w_rvalid),
            .i_right_present (w_rpres),
            .i_head_tag      (i_vpn),
            .i_head_frame    (w_head_frame),
            .i_head_valid    (w_head_valid),
            .o_tag           (w_tag[g]),
            .o_frame         (w_frame[g]),
            .o_valid         (w_valid[g]),
            .o_present       (w_present[g]),
            .o_match         (w_match[g])
        );
    end

    // Select the matching entry.
    always_comb begin
        w_sidx      = '0;
        w_sel_frame = '0;
        w_sel_valid = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_sidx      = w_sidx | IDX_W'(i);
                w_sel_frame = w_sel_frame | w_frame[i];
                w_sel_valid = w_sel_valid | w_valid[i];
            end
        end
        w_any = |w_match;
    end

    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_capacity);
        end
        w_full  = CMP_W'(r_count) >= w_eff_cap;
        w_limit = w_full ? (r_count - CNT_W'(1)) : r_count;
    end

    // Decode the request.
    always_comb begin
        w_lookup     = 1'b0;
        w_promote    = 1'b0;
        w_insert_new = 1'b0;
        w_drop       = 1'b0;
        case (atlb_pkg::t_opcode'(i_opcode))
            atlb_pkg::OP_LOOKUP: begin
                w_lookup  = 1'b1;
                w_promote = w_any && w_sel_valid && (r_policy == atlb_pkg::POLICY_LRU);
            end
            atlb_pkg::OP_INSERT: begin
                w_promote    = w_any && (r_policy == atlb_pkg::POLICY_LRU);
                w_insert_new = !w_any;
            end
            atlb_pkg::OP_INVAL: begin
                w_drop = w_any;
            end
            default: begin
            end
        endcase
        w_lookup_hit = w_lookup && w_any && w_sel_valid;
        w_head_frame = w_lookup ? w_sel_frame : i_frame;
        w_head_valid = w_lookup ? w_sel_valid : i_entry_valid;
    end

    // Per-cell shift commands.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_cmd[i] = atlb_pkg::CMD_HOLD;
            if (w_accept) begin
                if (w_promote) begin
                    if (i == 0) begin
                        w_cmd[i] = atlb_pkg::CMD_LOAD;
                    end else if (IDX_W'(i) <= w_sidx) begin
                        w_cmd[i] = atlb_pkg::CMD_LEFT;
                    end
                end else if (w_insert_new) begin
                    if (i == 0) begin
                        w_cmd[i] = atlb_pkg::CMD_LOAD;
                    end else if (CNT_W'(i) <= w_limit) begin
                        w_cmd[i] = atlb_pkg::CMD_LEFT;
                    end
                end else if (w_drop) begin
                    if (IDX_W'(i) >= w_sidx) begin
                        w_cmd[i] = atlb_pkg::CMD_RIGHT;
                    end
                end
            end
        end
    end

    // Occupancy, totals and the result word.
    always_comb begin
        n_count     = r_count;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_hit       = r_hit;
        n_frame_out = r_frame_out;
        if (w_accept) begin
            if (w_insert_new && !w_full) begin
                n_count = r_count + CNT_W'(1);
            end else if (w_drop) begin
                n_count = r_count - CNT_W'(1);
            end
            if (w_lookup_hit) begin
                if (r_hit_cnt != '1) begin
                    n_hit_cnt = r_hit_cnt + atlb_pkg::STAT_BITS'(1);
                end
            end else if (w_lookup) begin
                if (r_miss_cnt != '1) begin
                    n_miss_cnt = r_miss_cnt + atlb_pkg::STAT_BITS'(1);
                end
            end
            n_hit       = w_lookup_hit;
            n_frame_out = w_lookup_hit ? w_sel_frame : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_out_valid <= w_accept || o_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit       <= n_hit;
        r_frame_out <= n_frame_out;
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_frame_out  = r_frame_out;
    assign o_occupancy  = r_count;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one entry matches the key");

    a_count_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_present) == r_count)
        else $error("occupancy disagrees with present entries");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("occupancy above table size");

    a_hit_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_lookup_hit) |=> (o_hit && r_count != '0))
        else $error("hit reported with empty table");

endmodule

`default_nettype wire

### sv/atlb_cell.sv
// One entry of the age-ordered translation chain: tag, frame, valid flag, present bit.
// Depends on atlb_pkg for the cell command type.
`default_nettype none

module atlb_cell #(
    parameter int VPN_BITS   = 52,
    parameter int FRAME_BITS = 40
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  atlb_pkg::t_cell_cmd        i_cmd,
    input  wire  [VPN_BITS-1:0]        i_key,
    input  wire  [VPN_BITS-1:0]        i_left_tag,
    input  wire  [FRAME_BITS-1:0]      i_left_frame,
    input  wire                        i_left_valid,
    input  wire                        i_left_present,
    input  wire  [VPN_BITS-1:0]        i_right_tag,
    input  wire  [FRAME_BITS-1:0]      i_right_frame,
    input  wire                        i_right_valid,
    input  wire                        i_right_present,
    input  wire  [VPN_BITS-1:0]        i_head_tag,
    input  wire  [FRAME_BITS-1:0]      i_head_frame,
    input  wire                        i_head_valid,
    output logic [VPN_BITS-1:0]        o_tag,
    output logic [FRAME_BITS-1:0]      o_frame,
    output logic                       o_valid,
    output logic                       o_present,
    output logic                       o_match
);

    logic [VPN_BITS-1:0]   r_tag,     n_tag;
    logic [FRAME_BITS-1:0] r_frame,   n_frame;
    logic                  r_valid,   n_valid;
    logic                  r_present, n_present;

    always_comb begin
        n_tag     = r_tag;
        n_frame   = r_frame;
        n_valid   = r_valid;
        n_present = r_present;
        case (i_cmd)
            atlb_pkg::CMD_LEFT: begin
                n_tag     = i_left_tag;
                n_frame   = i_left_frame;
                n_valid   = i_left_valid;
                n_present = i_left_present;
            end
            atlb_pkg::CMD_RIGHT: begin
                n_tag     = i_right_tag;
                n_frame   = i_right_frame;
                n_valid   = i_right_valid;
                n_present = i_right_present;
            end
            atlb_pkg::CMD_LOAD: begin
                n_tag     = i_head_tag;
                n_frame   = i_head_frame;
                n_valid   = i_head_valid;
                n_present = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_frame <= n_frame;
        r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
        end else begin
            r_present <= n_present;
        end
    end

    assign o_tag     = r_tag;
    assign o_frame   = r_frame;
    assign o_valid   = r_valid;
    assign o_present = r_present;
    assign o_match   = r_present && (r_tag == i_key);

endmodule

`default_nettype wire
